// ===== hw/rtl/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, codes and types of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    // slot table geometry
    localparam int MAX_VOICES = 32;
    localparam int MIN_VOICES = 2;
    localparam int SLOT_BITS  = 5;
    localparam int COUNT_BITS = 6;
    localparam int TIME_BITS  = 32;
    localparam int KEY_BITS   = 7;
    localparam int OP_BITS    = 3;
    localparam int ACT_BITS   = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(8);

    // pedal is down above this level
    localparam logic [KEY_BITS-1:0] PEDAL_THRESHOLD = KEY_BITS'(63);

    // command opcodes
    localparam logic [OP_BITS-1:0] OP_NOTE_ON       = 3'd0;
    localparam logic [OP_BITS-1:0] OP_NOTE_OFF      = 3'd1;
    localparam logic [OP_BITS-1:0] OP_PEDAL         = 3'd2;
    localparam logic [OP_BITS-1:0] OP_ALL_NOTES_OFF = 3'd3;
    localparam logic [OP_BITS-1:0] OP_ALL_SOUND_OFF = 3'd4;

    // result action codes
    localparam logic [ACT_BITS-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_ASSIGN  = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_STEAL   = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_FREE    = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_RELEASE = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_SUS_ON  = 3'd5;
    localparam logic [ACT_BITS-1:0] ACT_SUS_OFF = 3'd6;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic flush;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic note_on;
    } ctrl_stat_t;

    // number of slots in use, clamped to the legal range
    function automatic logic [COUNT_BITS-1:0] clamp_count(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = v;
        if (v < COUNT_BITS'(MIN_VOICES))
        begin
            r = COUNT_BITS'(MIN_VOICES);
        end
        else if (v > COUNT_BITS'(MAX_VOICES))
        begin
            r = COUNT_BITS'(MAX_VOICES);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/poly_voice_allocator.sv =====
// Sequence: a command walks n slots (n = clamped voice count, 2..32), one slot per cycle,
// with busy high; a note-on then adds a commit step to write the chosen slot, and a flush
// step ends every command. A new command is taken only while busy is low.
// Results: one-cycle strobed words in slot order; the last is out in the first cycle busy is low.
// Reset (rst_n low, asynchronous): all slots free, voice count 8, no result pending.
// ----------------------------------------------------------------------------
// poly_voice_allocator
// Polyphonic voice allocator with oldest-note stealing: sequencer plus
// slot table datapath.
// ----------------------------------------------------------------------------
module poly_voice_allocator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [pva_pkg::OP_BITS-1:0]           opcode,
    input  logic [pva_pkg::KEY_BITS-1:0]          note,
    input  logic [pva_pkg::KEY_BITS-1:0]          velocity,
    input  logic [pva_pkg::KEY_BITS-1:0]          pedal_value,
    input  logic [pva_pkg::TIME_BITS-1:0]         timestamp,
    input  logic                                  cfg_wr_en,
    input  logic [pva_pkg::COUNT_BITS-1:0]        cfg_wr_data,
    output logic                                  result_strobe,
    output logic [pva_pkg::SLOT_BITS-1:0]         slot_index,
    output logic [pva_pkg::ACT_BITS-1:0]          action,
    output logic [pva_pkg::KEY_BITS-1:0]          slot_note,
    output logic [pva_pkg::KEY_BITS-1:0]          slot_velocity,
    output logic [pva_pkg::KEY_BITS-1:0]          stolen_note,
    output logic                                  last
);

    pva_pkg::ctrl_cmd_t  cmd;
    pva_pkg::ctrl_stat_t stat;

    // sequencer
    pva_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // slot table and result staging
    pva_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .note          (note),
        .velocity      (velocity),
        .pedal_value   (pedal_value),
        .timestamp     (timestamp),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .result_strobe (result_strobe),
        .slot_index    (slot_index),
        .action        (action),
        .slot_note     (slot_note),
        .slot_velocity (slot_velocity),
        .stolen_note   (stolen_note),
        .last          (last)
    );

endmodule

// ===== hw/rtl/pva_ctrl.sv =====
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer: accepts a command, walks the slot scan, commits a note-on and
// flushes the final result word.
// ----------------------------------------------------------------------------
module pva_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pva_pkg::ctrl_stat_t stat,
    output pva_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);

    pva_pkg::state_t state_reg;
    pva_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pva_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pva_pkg::ST_SCAN;
                end
            end
            pva_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = stat.note_on ? pva_pkg::ST_COMMIT : pva_pkg::ST_FLUSH;
                end
            end
            pva_pkg::ST_COMMIT:
            begin
                state_next = pva_pkg::ST_FLUSH;
            end
            pva_pkg::ST_FLUSH:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            pva_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            pva_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            pva_pkg::ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pva_datapath.sv =====
// ----------------------------------------------------------------------------
// pva_datapath
// Slot table, scan index, note-on search and result word staging.
// ----------------------------------------------------------------------------
module pva_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pva_pkg::ctrl_cmd_t                    cmd,
    output pva_pkg::ctrl_stat_t                   stat,
    input  logic [pva_pkg::OP_BITS-1:0]           opcode,
    input  logic [pva_pkg::KEY_BITS-1:0]          note,
    input  logic [pva_pkg::KEY_BITS-1:0]          velocity,
    input  logic [pva_pkg::KEY_BITS-1:0]          pedal_value,
    input  logic [pva_pkg::TIME_BITS-1:0]         timestamp,
    input  logic                                  cfg_wr_en,
    input  logic [pva_pkg::COUNT_BITS-1:0]        cfg_wr_data,
    output logic                                  result_strobe,
    output logic [pva_pkg::SLOT_BITS-1:0]         slot_index,
    output logic [pva_pkg::ACT_BITS-1:0]          action,
    output logic [pva_pkg::KEY_BITS-1:0]          slot_note,
    output logic [pva_pkg::KEY_BITS-1:0]          slot_velocity,
    output logic [pva_pkg::KEY_BITS-1:0]          stolen_note,
    output logic                                  last
);

    // latched command word
    logic [pva_pkg::OP_BITS-1:0]    op_reg;
    logic [pva_pkg::KEY_BITS-1:0]   note_reg;
    logic [pva_pkg::KEY_BITS-1:0]   vel_reg;
    logic                           down_reg;
    logic [pva_pkg::TIME_BITS-1:0]  time_reg;

    // configuration and scan position
    logic [pva_pkg::COUNT_BITS-1:0] count_reg;
    logic [pva_pkg::COUNT_BITS-1:0] used_count;
    logic [pva_pkg::COUNT_BITS-1:0] cfg_count;
    logic [pva_pkg::SLOT_BITS-1:0]  idx_reg;

    // slot flags
    logic [pva_pkg::MAX_VOICES-1:0] active_reg;
    logic [pva_pkg::MAX_VOICES-1:0] sus_reg;
    logic [pva_pkg::MAX_VOICES-1:0] rel_reg;

    // slot payload
    logic [pva_pkg::KEY_BITS-1:0]   key_mem  [pva_pkg::MAX_VOICES];
    logic [pva_pkg::KEY_BITS-1:0]   str_mem  [pva_pkg::MAX_VOICES];
    logic [pva_pkg::TIME_BITS-1:0]  time_mem [pva_pkg::MAX_VOICES];

    // note-on search
    logic                           free_found_reg;
    logic [pva_pkg::SLOT_BITS-1:0]  free_idx_reg;
    logic [pva_pkg::SLOT_BITS-1:0]  min_idx_reg;
    logic [pva_pkg::TIME_BITS-1:0]  min_time_reg;
    logic [pva_pkg::KEY_BITS-1:0]   min_key_reg;

    // pending result word
    logic                           pend_valid_reg;
    logic [pva_pkg::SLOT_BITS-1:0]  pend_idx_reg;
    logic [pva_pkg::ACT_BITS-1:0]   pend_act_reg;
    logic [pva_pkg::KEY_BITS-1:0]   pend_note_reg;
    logic [pva_pkg::KEY_BITS-1:0]   pend_vel_reg;
    logic [pva_pkg::KEY_BITS-1:0]   pend_stolen_reg;

    // output register
    logic                           strobe_reg;
    logic [pva_pkg::SLOT_BITS-1:0]  out_idx_reg;
    logic [pva_pkg::ACT_BITS-1:0]   out_act_reg;
    logic [pva_pkg::KEY_BITS-1:0]   out_note_reg;
    logic [pva_pkg::KEY_BITS-1:0]   out_vel_reg;
    logic [pva_pkg::KEY_BITS-1:0]   out_stolen_reg;
    logic                           out_last_reg;

    // current slot view and its update
    logic                           cur_act;
    logic                           cur_sus;
    logic                           cur_rel;
    logic [pva_pkg::KEY_BITS-1:0]   cur_key;
    logic [pva_pkg::KEY_BITS-1:0]   cur_str;
    logic [pva_pkg::TIME_BITS-1:0]  cur_time;
    logic                           act_next;
    logic                           sus_next;
    logic                           rel_next;
    logic                           hit;
    logic [pva_pkg::ACT_BITS-1:0]   hit_act;
    logic                           take_min;
    logic [pva_pkg::SLOT_BITS-1:0]  pick_idx;
    logic                           emit_now;

    assign used_count = pva_pkg::clamp_count(count_reg);
    assign cfg_count  = pva_pkg::clamp_count(cfg_wr_data);

    assign cur_act  = active_reg[idx_reg];
    assign cur_sus  = sus_reg[idx_reg];
    assign cur_rel  = rel_reg[idx_reg];
    assign cur_key  = key_mem[idx_reg];
    assign cur_str  = str_mem[idx_reg];
    assign cur_time = time_mem[idx_reg];

    assign stat.scan_done = ({1'b0, idx_reg} == (used_count - 1'b1));
    assign stat.note_on   = (op_reg == pva_pkg::OP_NOTE_ON);

    assign take_min = (idx_reg == '0) || (cur_time < min_time_reg);
    assign pick_idx = free_found_reg ? free_idx_reg : min_idx_reg;

    // per-slot action for the current command
    always_comb
    begin
        act_next = cur_act;
        sus_next = cur_sus;
        rel_next = cur_rel;
        hit      = 1'b0;
        hit_act  = pva_pkg::ACT_NONE;
        case (op_reg)
            pva_pkg::OP_NOTE_OFF:
            begin
                if (cur_act && (cur_key == note_reg))
                begin
                    if (!cur_sus)
                    begin
                        act_next = 1'b0;
                        hit      = 1'b1;
                        hit_act  = pva_pkg::ACT_FREE;
                    end
                    else if (!cur_rel)
                    begin
                        rel_next = 1'b1;
                        hit      = 1'b1;
                        hit_act  = pva_pkg::ACT_RELEASE;
                    end
                end
            end
            pva_pkg::OP_PEDAL:
            begin
                if (cur_act)
                begin
                    if (down_reg)
                    begin
                        if (!cur_sus)
                        begin
                            sus_next = 1'b1;
                            hit      = 1'b1;
                            hit_act  = pva_pkg::ACT_SUS_ON;
                        end
                    end
                    else if (cur_rel)
                    begin
                        act_next = 1'b0;
                        sus_next = 1'b0;
                        rel_next = 1'b0;
                        hit      = 1'b1;
                        hit_act  = pva_pkg::ACT_FREE;
                    end
                    else if (cur_sus)
                    begin
                        sus_next = 1'b0;
                        hit      = 1'b1;
                        hit_act  = pva_pkg::ACT_SUS_OFF;
                    end
                end
            end
            pva_pkg::OP_ALL_NOTES_OFF:
            begin
                if (cur_act && !cur_sus)
                begin
                    act_next = 1'b0;
                    hit      = 1'b1;
                    hit_act  = pva_pkg::ACT_FREE;
                end
            end
            pva_pkg::OP_ALL_SOUND_OFF:
            begin
                act_next = 1'b0;
                sus_next = 1'b0;
                rel_next = 1'b0;
                if (cur_act)
                begin
                    hit     = 1'b1;
                    hit_act = pva_pkg::ACT_FREE;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    // a staged word goes out when a newer one replaces it or at the flush
    assign emit_now = pend_valid_reg && ((cmd.scan && hit) || cmd.flush);

    // command latch and note-on search, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            note_reg <= note;
            vel_reg  <= velocity;
            down_reg <= (pedal_value > pva_pkg::PEDAL_THRESHOLD);
            time_reg <= timestamp;
        end
        if (cmd.load)
        begin
            free_idx_reg <= '0;
        end
        else if (cmd.scan && !free_found_reg && !cur_act)
        begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.scan && take_min)
        begin
            min_idx_reg  <= idx_reg;
            min_time_reg <= cur_time;
            min_key_reg  <= cur_key;
        end
    end

    // slot payload writes on note-on commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            key_mem[pick_idx]  <= note_reg;
            str_mem[pick_idx]  <= vel_reg;
            time_mem[pick_idx] <= time_reg;
        end
    end

    // control state: count, scan index, flags, search and staging valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= pva_pkg::COUNT_RESET;
            idx_reg        <= '0;
            active_reg     <= '0;
            sus_reg        <= '0;
            rel_reg        <= '0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
                for (int i = 0; i < pva_pkg::MAX_VOICES; i++)
                begin
                    if (pva_pkg::COUNT_BITS'(i) >= cfg_count)
                    begin
                        active_reg[i] <= 1'b0;
                        sus_reg[i]    <= 1'b0;
                        rel_reg[i]    <= 1'b0;
                    end
                end
            end
            if (cmd.load)
            begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                idx_reg              <= idx_reg + 1'b1;
                active_reg[idx_reg]  <= act_next;
                sus_reg[idx_reg]     <= sus_next;
                rel_reg[idx_reg]     <= rel_next;
                if (!cur_act)
                begin
                    free_found_reg <= 1'b1;
                end
                if (hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                active_reg[pick_idx] <= 1'b1;
                sus_reg[pick_idx]    <= 1'b0;
                rel_reg[pick_idx]    <= 1'b0;
                pend_valid_reg       <= 1'b1;
            end
            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // staged result word
    always_ff @(posedge clk)
    begin
        if (cmd.scan && hit)
        begin
            pend_idx_reg    <= idx_reg;
            pend_act_reg    <= hit_act;
            pend_note_reg   <= cur_key;
            pend_vel_reg    <= cur_str;
            pend_stolen_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pend_idx_reg    <= pick_idx;
            pend_act_reg    <= free_found_reg ? pva_pkg::ACT_ASSIGN : pva_pkg::ACT_STEAL;
            pend_note_reg   <= note_reg;
            pend_vel_reg    <= vel_reg;
            pend_stolen_reg <= free_found_reg ? '0 : min_key_reg;
        end
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit_now;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            out_idx_reg    <= pend_idx_reg;
            out_act_reg    <= pend_act_reg;
            out_note_reg   <= pend_note_reg;
            out_vel_reg    <= pend_vel_reg;
            out_stolen_reg <= pend_stolen_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign result_strobe = strobe_reg;
    assign slot_index    = out_idx_reg;
    assign action        = out_act_reg;
    assign slot_note     = out_note_reg;
    assign slot_velocity = out_vel_reg;
    assign stolen_note   = out_stolen_reg;
    assign last          = out_last_reg;

endmodule

// ===== hw/rtl/pva_checker.sv =====
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_port_checks (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  result_strobe,
    input logic [pva_pkg::ACT_BITS-1:0]          action,
    input logic [pva_pkg::KEY_BITS-1:0]          stolen_note,
    input logic                                  last
);

    // an accepted command keeps the block busy for the scan
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    // no word follows the final word of a command right away
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result word right after the final word");

    // a note-on word is always the final word of its command
    a_note_on_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (action == pva_pkg::ACT_ASSIGN || action == pva_pkg::ACT_STEAL))
        |-> last)
        else $error("note-on word not marked final");

    // stolen note only reported on a steal
    a_stolen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && action != pva_pkg::ACT_STEAL) |-> (stolen_note == '0))
        else $error("stolen note set on a word that is not a steal");

    // every word carries a real action
    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (action != pva_pkg::ACT_NONE && action <= pva_pkg::ACT_SUS_OFF))
        else $error("result word with no action");

endmodule

bind poly_voice_allocator pva_port_checks u_pva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .action        (action),
    .stolen_note   (stolen_note),
    .last          (last)
);

// ===== verif/pva_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pva_checker
// Watches the command, config and result ports of the voice allocator,
// keeps its own copy of the voice slot table, predicts the slot events
// that each accepted command word causes and compares every result word
// with the oldest prediction.
// ----------------------------------------------------------------------------
module pva_checker
    import pva_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [OP_BITS-1:0]    opcode,
    input  logic [KEY_BITS-1:0]   note,
    input  logic [KEY_BITS-1:0]   velocity,
    input  logic [KEY_BITS-1:0]   pedal_value,
    input  logic [TIME_BITS-1:0]  timestamp,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    input  logic                  result_strobe,
    input  logic [SLOT_BITS-1:0]  slot_index,
    input  logic [ACT_BITS-1:0]   action,
    input  logic [KEY_BITS-1:0]   slot_note,
    input  logic [KEY_BITS-1:0]   slot_velocity,
    input  logic [KEY_BITS-1:0]   stolen_note,
    input  logic                  last,
    output int                    error_count,
    output int                    pending_words
);

    // one slot event, as carried by a result word
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [ACT_BITS-1:0]  act;
        logic [KEY_BITS-1:0]  key;
        logic [KEY_BITS-1:0]  strength;
        logic [KEY_BITS-1:0]  cut_key;
        logic                 final_word;
    } slot_event_t;

    // shadow slot table
    logic [MAX_VOICES-1:0] voice_on;
    logic [MAX_VOICES-1:0] voice_held;
    logic [MAX_VOICES-1:0] voice_let_go;
    logic [KEY_BITS-1:0]   voice_key [MAX_VOICES];
    logic [KEY_BITS-1:0]   voice_strength [MAX_VOICES];
    logic [TIME_BITS-1:0]  voice_start [MAX_VOICES];
    int                    slots_in_use;

    slot_event_t events_due [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
        begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
        end
    endtask

    task automatic wipe_slot(input int s);
        voice_on[s]       = 1'b0;
        voice_held[s]     = 1'b0;
        voice_let_go[s]   = 1'b0;
        voice_key[s]      = '0;
        voice_strength[s] = '0;
        voice_start[s]    = '0;
    endtask

    // new voice count: clamp, then slots past the count go back to reset
    task automatic set_voice_count(input logic [COUNT_BITS-1:0] value);
        slots_in_use = int'(value);
        if (slots_in_use < MIN_VOICES)
        begin
            slots_in_use = MIN_VOICES;
        end
        if (slots_in_use > MAX_VOICES)
        begin
            slots_in_use = MAX_VOICES;
        end
        for (int s = slots_in_use; s < MAX_VOICES; s++)
        begin
            wipe_slot(s);
        end
    endtask

    function automatic slot_event_t slot_event(input int s, input logic [ACT_BITS-1:0] a,
                                               input logic [KEY_BITS-1:0] cut);
        slot_event_t ev;
        ev.slot       = SLOT_BITS'(s);
        ev.act        = a;
        ev.key        = voice_key[s];
        ev.strength   = voice_strength[s];
        ev.cut_key    = cut;
        ev.final_word = 1'b0;
        return ev;
    endfunction

    // apply one command word to the shadow table and queue its slot events
    task automatic allocate_voices(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                                   input logic [KEY_BITS-1:0] strength,
                                   input logic [KEY_BITS-1:0] pedal,
                                   input logic [TIME_BITS-1:0] now);
        slot_event_t evs [MAX_VOICES];
        int          n_ev;
        int          pick;
        logic [ACT_BITS-1:0] how;
        logic [KEY_BITS-1:0] cut;
        logic        pedal_down;
        n_ev       = 0;
        pedal_down = pedal > PEDAL_THRESHOLD;
        case (op)
            OP_NOTE_ON:
            begin
                pick = -1;
                how  = ACT_ASSIGN;
                cut  = '0;
                for (int s = 0; s < slots_in_use; s++)
                begin
                    if (!voice_on[s] && pick < 0)
                    begin
                        pick = s;
                    end
                end
                // table full: take the oldest voice, lowest slot on ties
                if (pick < 0)
                begin
                    pick = 0;
                    for (int s = 1; s < slots_in_use; s++)
                    begin
                        if (voice_start[s] < voice_start[pick])
                        begin
                            pick = s;
                        end
                    end
                    how = ACT_STEAL;
                    cut = voice_key[pick];
                end
                voice_on[pick]       = 1'b1;
                voice_key[pick]      = key;
                voice_strength[pick] = strength;
                voice_start[pick]    = now;
                voice_held[pick]     = 1'b0;
                voice_let_go[pick]   = 1'b0;
                evs[n_ev] = slot_event(pick, how, cut);
                n_ev++;
            end
            OP_NOTE_OFF:
            begin
                for (int s = 0; s < slots_in_use; s++)
                begin
                    if (voice_on[s] && voice_key[s] == key)
                    begin
                        if (!voice_held[s])
                        begin
                            voice_on[s] = 1'b0;
                            evs[n_ev] = slot_event(s, ACT_FREE, '0);
                            n_ev++;
                        end
                        else if (!voice_let_go[s])
                        begin
                            voice_let_go[s] = 1'b1;
                            evs[n_ev] = slot_event(s, ACT_RELEASE, '0);
                            n_ev++;
                        end
                    end
                end
            end
            OP_PEDAL:
            begin
                for (int s = 0; s < slots_in_use; s++)
                begin
                    if (voice_on[s])
                    begin
                        if (pedal_down)
                        begin
                            if (!voice_held[s])
                            begin
                                voice_held[s] = 1'b1;
                                evs[n_ev] = slot_event(s, ACT_SUS_ON, '0);
                                n_ev++;
                            end
                        end
                        else if (voice_let_go[s])
                        begin
                            voice_on[s]     = 1'b0;
                            voice_held[s]   = 1'b0;
                            voice_let_go[s] = 1'b0;
                            evs[n_ev] = slot_event(s, ACT_FREE, '0);
                            n_ev++;
                        end
                        else if (voice_held[s])
                        begin
                            voice_held[s] = 1'b0;
                            evs[n_ev] = slot_event(s, ACT_SUS_OFF, '0);
                            n_ev++;
                        end
                    end
                end
            end
            OP_ALL_NOTES_OFF:
            begin
                for (int s = 0; s < slots_in_use; s++)
                begin
                    if (voice_on[s] && !voice_held[s])
                    begin
                        voice_on[s] = 1'b0;
                        evs[n_ev] = slot_event(s, ACT_FREE, '0);
                        n_ev++;
                    end
                end
            end
            OP_ALL_SOUND_OFF:
            begin
                for (int s = 0; s < slots_in_use; s++)
                begin
                    voice_held[s]   = 1'b0;
                    voice_let_go[s] = 1'b0;
                    if (voice_on[s])
                    begin
                        voice_on[s] = 1'b0;
                        evs[n_ev] = slot_event(s, ACT_FREE, '0);
                        n_ev++;
                    end
                end
            end
            default:
            begin
                // unused opcodes leave the table alone
            end
        endcase
        if (n_ev > 0)
        begin
            evs[n_ev-1].final_word = 1'b1;
        end
        for (int e = 0; e < n_ev; e++)
        begin
            events_due.insert(events_due.size(), evs[e]);
        end
    endtask

    // watch the ports: results first, then new command words and config writes
    always @(posedge clk or negedge rst_n)
    begin
        slot_event_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_VOICES; s++)
            begin
                wipe_slot(s);
            end
            slots_in_use = int'(COUNT_RESET);
            events_due.delete();
            pending_words = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (events_due.size() == 0)
                begin
                    report_mismatch($sformatf("result word for slot %0d with none expected",
                                              slot_index));
                end
                else
                begin
                    want = events_due.pop_front();
                    check_field("slot_index", 32'(slot_index), 32'(want.slot));
                    check_field("action", 32'(action), 32'(want.act));
                    check_field("slot_note", 32'(slot_note), 32'(want.key));
                    check_field("slot_velocity", 32'(slot_velocity), 32'(want.strength));
                    check_field("stolen_note", 32'(stolen_note), 32'(want.cut_key));
                    check_field("last", 32'(last), 32'(want.final_word));
                end
            end
            if (start && !busy)
            begin
                allocate_voices(opcode, note, velocity, pedal_value, timestamp);
            end
            if (cfg_wr_en)
            begin
                set_voice_count(cfg_wr_data);
            end
            pending_words = events_due.size();
        end
    end

    initial
    begin
        error_count   = 0;
        pending_words = 0;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives note, pedal and panic commands into the voice allocator through a
// directed opening and randomized phases at several voice counts and sender
// idle rates; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import pva_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_WORDS   = 50;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_BITS-1:0]    opcode = OP_NOTE_ON;
    logic [KEY_BITS-1:0]   note = '0;
    logic [KEY_BITS-1:0]   velocity = '0;
    logic [KEY_BITS-1:0]   pedal_value = '0;
    logic [TIME_BITS-1:0]  timestamp = '0;
    logic                  cfg_wr_en = 1'b0;
    logic [COUNT_BITS-1:0] cfg_wr_data = '0;
    logic                  result_strobe;
    logic [SLOT_BITS-1:0]  slot_index;
    logic [ACT_BITS-1:0]   action;
    logic [KEY_BITS-1:0]   slot_note;
    logic [KEY_BITS-1:0]   slot_velocity;
    logic [KEY_BITS-1:0]   stolen_note;
    logic                  last;

    int                    error_count;
    int                    pending_words;
    int                    cycle_count = 0;
    logic [TIME_BITS-1:0]  song_time = '0;
    logic [COUNT_BITS-1:0] phase_counts [8];
    int                    phase_idle [3];

    poly_voice_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .note          (note),
        .velocity      (velocity),
        .pedal_value   (pedal_value),
        .timestamp     (timestamp),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .result_strobe (result_strobe),
        .slot_index    (slot_index),
        .action        (action),
        .slot_note     (slot_note),
        .slot_velocity (slot_velocity),
        .stolen_note   (stolen_note),
        .last          (last)
    );

    pva_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .note          (note),
        .velocity      (velocity),
        .pedal_value   (pedal_value),
        .timestamp     (timestamp),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .result_strobe (result_strobe),
        .slot_index    (slot_index),
        .action        (action),
        .slot_note     (slot_note),
        .slot_velocity (slot_velocity),
        .stolen_note   (stolen_note),
        .last          (last),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // present one command word and hold it until the block takes it
    task automatic send_command(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] key,
                                input logic [KEY_BITS-1:0] strength,
                                input logic [KEY_BITS-1:0] pedal,
                                input logic [TIME_BITS-1:0] now);
        start       <= 1'b1;
        opcode      <= op;
        note        <= key;
        velocity    <= strength;
        pedal_value <= pedal;
        timestamp   <= now;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // random idle cycles before the next word
    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // wait until every predicted word has come back and the block is idle
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_words != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_voice_count(input logic [COUNT_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // opening sequence at the reset voice count of eight
    task automatic directed_commands;
        // commands on an empty table
        send_command(OP_NOTE_OFF, 7'd0, 7'd0, 7'd0, 32'd0);
        send_command(OP_PEDAL, 7'd127, 7'd127, 7'd0, 32'd0);
        send_command(OP_ALL_NOTES_OFF, 7'd85, 7'd42, 7'd127, 32'hFFFF_FFFF);
        send_command(OP_ALL_SOUND_OFF, 7'd42, 7'd85, 7'd64, 32'h5555_5555);
        // fill all eight slots, ties on start time in most of them
        send_command(OP_NOTE_ON, 7'd0, 7'd0, 7'd0, 32'd500);
        send_command(OP_NOTE_ON, 7'd127, 7'd127, 7'd127, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++)
        begin
            send_command(OP_NOTE_ON, KEY_BITS'(60 + k), 7'd64, 7'd0, 32'd500);
        end
        // full table: oldest voice is stolen, lowest slot on a tie
        send_command(OP_NOTE_ON, 7'd66, 7'd100, 7'd0, 32'd1000);
        send_command(OP_NOTE_ON, 7'd67, 7'd1, 7'd0, 32'd1000);
        // sustain, release under sustain, repeated pedal and note-off
        send_command(OP_PEDAL, 7'd0, 7'd0, 7'd64, 32'd0);
        send_command(OP_PEDAL, 7'd0, 7'd0, 7'd127, 32'd0);
        send_command(OP_NOTE_OFF, 7'd127, 7'd0, 7'd0, 32'd0);
        send_command(OP_NOTE_OFF, 7'd127, 7'd0, 7'd0, 32'd0);
        send_command(OP_ALL_NOTES_OFF, 7'd0, 7'd0, 7'd0, 32'd0);
        send_command(OP_PEDAL, 7'd0, 7'd0, 7'd63, 32'd0);
        send_command(OP_PEDAL, 7'd0, 7'd0, 7'd0, 32'd0);
        // same note in two slots, one note-off frees both
        send_command(OP_NOTE_ON, 7'd61, 7'd33, 7'd0, 32'd5);
        send_command(OP_NOTE_OFF, 7'd61, 7'd0, 7'd0, 32'd0);
        // unused opcodes
        send_command(OP_ALL_SOUND_OFF + 3'd1, 7'd60, 7'd60, 7'd127, 32'd7);
        send_command(OP_ALL_SOUND_OFF + 3'd3, 7'd62, 7'd60, 7'd0, 32'd7);
        send_command(OP_ALL_NOTES_OFF, 7'd0, 7'd0, 7'd0, 32'd0);
        // all sound off also clears sustained voices
        send_command(OP_NOTE_ON, 7'd10, 7'd20, 7'd0, 32'd9);
        send_command(OP_PEDAL, 7'd0, 7'd0, 7'd100, 32'd0);
        send_command(OP_ALL_SOUND_OFF, 7'd0, 7'd0, 7'd0, 32'd0);
    endtask

    // random commands, notes mostly from a narrow range so note-offs match
    task automatic random_commands(input int words, input int idle_pct);
        int                   sent;
        int                   roll;
        logic [KEY_BITS-1:0]  key_base;
        logic [OP_BITS-1:0]   op;
        logic [KEY_BITS-1:0]  key;
        logic [TIME_BITS-1:0] now;
        sent     = 0;
        key_base = KEY_BITS'($urandom_range(120));
        while (sent < words)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                op = OP_NOTE_ON;
            end
            else if (roll < 70)
            begin
                op = OP_NOTE_OFF;
            end
            else if (roll < 85)
            begin
                op = OP_PEDAL;
            end
            else if (roll < 91)
            begin
                op = OP_ALL_NOTES_OFF;
            end
            else if (roll < 96)
            begin
                op = OP_ALL_SOUND_OFF;
            end
            else
            begin
                op = OP_ALL_SOUND_OFF + OP_BITS'($urandom_range(1, 3));
            end
            if ($urandom_range(99) < 75)
            begin
                key = key_base + KEY_BITS'($urandom_range(7));
            end
            else
            begin
                key = KEY_BITS'($urandom_range(127));
            end
            // time mostly creeps forward with repeats, sometimes jumps anywhere
            if ($urandom_range(9) == 0)
            begin
                now = $urandom;
            end
            else
            begin
                song_time = song_time + TIME_BITS'($urandom_range(2));
                now       = song_time;
            end
            sender_gap(idle_pct);
            send_command(op, key, KEY_BITS'($urandom_range(127)),
                         KEY_BITS'($urandom_range(127)), now);
            if (op <= OP_ALL_SOUND_OFF)
            begin
                sent++;
            end
        end
    endtask

    initial
    begin
        phase_counts = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd5, 6'd0};
        phase_counts[7] = COUNT_BITS'($urandom_range(63));
        phase_idle   = '{0, 88, 23};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_commands();
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_voice_count(phase_counts[p]);
            random_commands(PHASE_WORDS, phase_idle[p % 3]);
            drain();
        end

        if (error_count == 0 && pending_words == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pva_pkg.sv
hw/rtl/pva_ctrl.sv
hw/rtl/pva_datapath.sv
hw/rtl/poly_voice_allocator.sv
hw/rtl/pva_checker.sv
verif/pva_checker.sv
verif/testbench.sv
